### design/dnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared types and constants for the DNS name decompressor.
// ----------------------------------------------------------------------------
package dnd_pkg;

  localparam int unsigned MsgBytesDef  = 512;
  localparam int unsigned NameBytesDef = 256;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_DECODE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_LONG  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_HOPS  = 2'd3;

  localparam logic [7:0] DOT_CHAR = 8'h2e;

  localparam logic [1:0] REG_MSG_LEN  = 2'd0;
  localparam logic [1:0] REG_MAX_HOPS = 2'd1;

  localparam logic [9:0] MSG_LEN_RST  = 10'd0;
  localparam logic [6:0] MAX_HOPS_RST = 7'd16;

  // One queued command from front to back.
  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] address;
    logic [7:0]  data;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_EXAM,
    S_PTR,
    S_COPY,
    S_RDWAIT,
    S_DONE
  } bk_state_t;

endpackage

### design/dnd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_front
// Accepts command beats and queues them (depth 2) for the back end.
// ----------------------------------------------------------------------------
module dnd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_start,
  input  logic [1:0]    in_func,
  input  logic [13:0]   in_address,
  input  logic [7:0]    in_data,
  output logic          full,
  input  logic          pop,
  output logic          q_valid,
  output dnd_pkg::cmd_t q_head
);

  dnd_pkg::cmd_t q_r [2];
  dnd_pkg::cmd_t q_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push;

  assign full    = (cnt_r == 2'd2);
  assign push    = in_start && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_r[0];

  always_comb begin
    q_nxt.func    = in_func;
    q_nxt.address = in_address;
    q_nxt.data    = in_data;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  // Shift queue: head at entry 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    if (pop) begin
      if (push && cnt_r == 2'd1) q_r[0] <= q_nxt;
      else q_r[0] <= q_r[1];
      if (push && cnt_r == 2'd2) q_r[1] <= q_nxt;
    end else if (push) begin
      if (cnt_r == 2'd0) q_r[0] <= q_nxt;
      else q_r[1] <= q_nxt;
    end
  end

endmodule

### design/dnd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnd_back
// Executes load, decode and read commands against the two byte stores.
// ----------------------------------------------------------------------------
module dnd_back #(
  parameter int unsigned MSG_BYTES  = dnd_pkg::MsgBytesDef,
  parameter int unsigned NAME_BYTES = dnd_pkg::NameBytesDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  dnd_pkg::cmd_t q_head,
  output logic          pop,
  input  logic [9:0]    msg_len,
  input  logic [6:0]    max_hops,
  output logic          out_strobe,
  output logic [7:0]    out_read_byte,
  output logic [7:0]    out_name_length,
  output logic [13:0]   out_next_offset,
  output logic [1:0]    out_status,
  output logic          idle
);

  localparam int MA = (MSG_BYTES > 1) ? $clog2(MSG_BYTES) : 1;
  localparam int NA = $clog2(NAME_BYTES);
  localparam logic [14:0] MsgB = 15'(MSG_BYTES);
  localparam logic [8:0]  NameMax = 9'(NAME_BYTES - 1);

  logic [7:0] mem_msg [MSG_BYTES];
  logic [7:0] mem_name [NAME_BYTES];

  dnd_pkg::bk_state_t st_r, st_nxt;
  dnd_pkg::cmd_t cmd_r;
  logic [13:0] pos_r;
  logic [6:0]  hops_r;
  logic [13:0] ret_r;
  logic        ret_set_r;
  logic [8:0]  n_r;
  logic [7:0]  cnt_r;
  logic [7:0]  hi_r;
  logic [7:0]  dlen_r;
  logic [7:0]  mrd_r, nrd_r;
  logic [14:0] lim;
  logic [14:0] rd_addr;
  logic        fin;
  logic [1:0]  fin_st;
  logic        res_v_r;
  logic [7:0]  res_rb_r, res_nl_r;
  logic [13:0] res_nx_r;
  logic [1:0]  res_st_r;
  logic [14:0] pos_end;
  logic [8:0]  need;

  assign lim = (msg_len > MsgB[9:0] && MSG_BYTES < 1024) ? MsgB : {5'd0, msg_len};
  assign pos_end = {1'b0, pos_r} + {7'd0, mrd_r};
  assign need = n_r + ((n_r != 9'd0) ? 9'd1 : 9'd0) + {1'b0, mrd_r};
  assign pop = (st_r == dnd_pkg::S_IDLE) && q_valid;
  assign idle = (st_r == dnd_pkg::S_IDLE) && !q_valid && !res_v_r;

  // Message address for the next byte fetch: one ahead while examining or copying.
  always_comb begin
    rd_addr = {1'b0, pos_r};
    if (st_r == dnd_pkg::S_EXAM || st_r == dnd_pkg::S_COPY) rd_addr = {1'b0, pos_r} + 15'd1;
  end

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      dnd_pkg::S_IDLE:   if (q_valid) st_nxt = (q_head.func == dnd_pkg::FUNC_DECODE)
                             ? dnd_pkg::S_FETCH : dnd_pkg::S_RDWAIT;
      dnd_pkg::S_FETCH:  st_nxt = ({1'b0, pos_r} >= lim) ? dnd_pkg::S_DONE : dnd_pkg::S_EXAM;
      dnd_pkg::S_EXAM:   begin
        if (mrd_r == 8'd0) st_nxt = dnd_pkg::S_DONE;
        else if ((mrd_r & 8'hc0) != 8'd0)
          st_nxt = ({1'b0, pos_r} + 15'd1 >= lim || hops_r >= max_hops)
                   ? dnd_pkg::S_DONE : dnd_pkg::S_PTR;
        else if (pos_end >= lim || need > NameMax) st_nxt = dnd_pkg::S_DONE;
        else st_nxt = dnd_pkg::S_COPY;
      end
      dnd_pkg::S_PTR:    st_nxt = dnd_pkg::S_FETCH;
      dnd_pkg::S_COPY:   if (cnt_r == 8'd1) st_nxt = dnd_pkg::S_FETCH;
      dnd_pkg::S_RDWAIT: st_nxt = dnd_pkg::S_IDLE;
      dnd_pkg::S_DONE:   st_nxt = dnd_pkg::S_IDLE;
      default:           st_nxt = dnd_pkg::S_IDLE;
    endcase
  end

  // Decode outcome, decided in the examine and fetch steps.
  always_comb begin
    fin = 1'b0;
    fin_st = dnd_pkg::ST_OK;
    if (st_r == dnd_pkg::S_FETCH && {1'b0, pos_r} >= lim) begin
      fin = 1'b1; fin_st = dnd_pkg::ST_RANGE;
    end else if (st_r == dnd_pkg::S_EXAM) begin
      if (mrd_r == 8'd0) begin
        fin = 1'b1;
      end else if ((mrd_r & 8'hc0) != 8'd0) begin
        if ({1'b0, pos_r} + 15'd1 >= lim) begin
          fin = 1'b1; fin_st = dnd_pkg::ST_RANGE;
        end else if (hops_r >= max_hops) begin
          fin = 1'b1; fin_st = dnd_pkg::ST_HOPS;
        end
      end else if (pos_end >= lim) begin
        fin = 1'b1; fin_st = dnd_pkg::ST_RANGE;
      end else if (need > NameMax) begin
        fin = 1'b1; fin_st = dnd_pkg::ST_LONG;
      end
    end
  end

  // Message store: written by loads, one registered read port.
  always_ff @(posedge clk) begin
    if (pop && q_head.func == dnd_pkg::FUNC_LOAD && {1'b0, q_head.address} < MsgB)
      mem_msg[q_head.address[MA-1:0]] <= q_head.data;
    mrd_r <= mem_msg[rd_addr[MA-1:0]];
  end

  // Name store: dot and label bytes written during copy.
  always_ff @(posedge clk) begin
    if (st_r == dnd_pkg::S_EXAM && st_nxt == dnd_pkg::S_COPY && n_r != 9'd0)
      mem_name[n_r[NA-1:0]] <= dnd_pkg::DOT_CHAR;
    else if (st_r == dnd_pkg::S_COPY)
      mem_name[n_r[NA-1:0]] <= mrd_r;
    nrd_r <= mem_name[q_head.address[NA-1:0]];
  end

  // Walk registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= dnd_pkg::S_IDLE;
      dlen_r <= 8'd0;
      res_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_v_r <= 1'b0;
      if (pop) begin
        cmd_r <= q_head;
        pos_r <= q_head.address;
        hops_r <= 7'd0;
        ret_set_r <= 1'b0;
        n_r <= 9'd0;
      end
      case (st_r)
        dnd_pkg::S_EXAM: begin
          if ((mrd_r & 8'hc0) != 8'd0) begin
            hi_r <= mrd_r;
            hops_r <= hops_r + 7'd1;
            if (!ret_set_r) begin
              ret_r <= pos_r + 14'd2;
              ret_set_r <= 1'b1;
            end
          end else begin
            cnt_r <= mrd_r;
            pos_r <= pos_r + 14'd1;
            if (n_r != 9'd0 && !fin) n_r <= n_r + 9'd1;
          end
        end
        dnd_pkg::S_PTR: pos_r <= {hi_r[5:0], mrd_r};
        dnd_pkg::S_COPY: begin
          n_r <= n_r + 9'd1;
          cnt_r <= cnt_r - 8'd1;
          pos_r <= pos_r + 14'd1;
        end
        default: ;
      endcase
      if (fin) begin
        res_v_r <= 1'b1;
        res_rb_r <= 8'd0;
        res_st_r <= fin_st;
        if (fin_st == dnd_pkg::ST_OK) begin
          dlen_r <= n_r[7:0];
          res_nl_r <= n_r[7:0];
          res_nx_r <= ret_set_r ? ret_r : pos_r + 14'd1;
        end else begin
          dlen_r <= 8'd0;
          res_nl_r <= 8'd0;
          res_nx_r <= 14'd0;
        end
      end
      if (st_r == dnd_pkg::S_RDWAIT) begin
        res_v_r <= 1'b1;
        res_rb_r <= 8'd0;
        res_nl_r <= 8'd0;
        res_nx_r <= 14'd0;
        res_st_r <= dnd_pkg::ST_OK;
        case (cmd_r.func)
          dnd_pkg::FUNC_LOAD:
            if ({1'b0, cmd_r.address} >= MsgB) res_st_r <= dnd_pkg::ST_RANGE;
          dnd_pkg::FUNC_READ: begin
            res_nl_r <= dlen_r;
            if (cmd_r.address < {6'd0, dlen_r}) res_rb_r <= nrd_r;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_strobe      = res_v_r;
  assign out_read_byte   = res_rb_r;
  assign out_name_length = res_nl_r;
  assign out_next_offset = res_nx_r;
  assign out_status      = res_st_r;

endmodule

### design/dns_name_decompressor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_name_decompressor_unit
// DNS wire-format name decoder with compression pointers, top level.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// in_*      input      beat taken when start && !busy
// out_*     output     one-cycle out_strobe, no back-pressure
// cfg/APB   input      write on psel && penable && pwrite (pready high)
//
// Load and read pass from the queue through the idle and read-wait states before
// out_strobe rises. Decode leaves the queue, then examines each length byte,
// copies each label's bytes, follows each pointer and stops at the end byte; the
// single message store read port sets this pace. A two-entry queue takes beats
// while the back end works; busy rises only when it is full. Reset clears
// control state; the byte stores have no reset and no clearing pass.
module dns_name_decompressor_unit #(
  parameter int unsigned MSG_BYTES  = dnd_pkg::MsgBytesDef,
  parameter int unsigned NAME_BYTES = dnd_pkg::NameBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [13:0] in_address,
  input  logic [7:0]  in_data,
  output logic        out_strobe,
  output logic [7:0]  out_read_byte,
  output logic [7:0]  out_name_length,
  output logic [13:0] out_next_offset,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0] msg_len_r;
  logic [6:0] max_hops_r;
  logic       q_valid, pop, idle;
  dnd_pkg::cmd_t q_head;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2] ? dnd_pkg::REG_MAX_HOPS : dnd_pkg::REG_MSG_LEN;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r  <= dnd_pkg::MSG_LEN_RST;
      max_hops_r <= dnd_pkg::MAX_HOPS_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      if (reg_idx == dnd_pkg::REG_MSG_LEN) msg_len_r <= pwdata[9:0];
      else max_hops_r <= pwdata[6:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[1:0] == 2'd0) begin
      if (reg_idx == dnd_pkg::REG_MSG_LEN) prdata = {22'd0, msg_len_r};
      else prdata = {25'd0, max_hops_r};
    end
  end

  dnd_front u_front (
    .clk(clk), .rst_n(rst_n), .in_start(start), .in_func(in_func),
    .in_address(in_address), .in_data(in_data), .full(busy), .pop(pop),
    .q_valid(q_valid), .q_head(q_head)
  );

  dnd_back #(.MSG_BYTES(MSG_BYTES), .NAME_BYTES(NAME_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_head(q_head), .pop(pop),
    .msg_len(msg_len_r), .max_hops(max_hops_r), .out_strobe(out_strobe),
    .out_read_byte(out_read_byte), .out_name_length(out_name_length),
    .out_next_offset(out_next_offset), .out_status(out_status), .idle(idle)
  );

  // A failed decode reports no length or offset.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != dnd_pkg::ST_OK |-> out_name_length == 8'd0)
    else $error("failed result with nonzero length");

  // Only reads return a name byte, and never past the length.
  a_rb_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_read_byte != 8'd0 |-> out_name_length != 8'd0)
    else $error("read byte without a name");

  // An idle back end with an empty queue leaves the input open.
  a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
    idle |-> !busy)
    else $error("busy while idle");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the DNS name decompressor. It fills the message
// store with a crafted image, runs a short table of hand-picked commands
// (plain names, pointers, pointer chains, loops, overlong names, bound
// errors), then random episodes. Each episode loads a few names with random
// labels and pointers, sets the registers and issues decodes and reads.
// Result beats are checked field by field against the model or a typed row.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    logic [7:0]  read_byte;
    logic [7:0]  name_length;
    logic [13:0] next_offset;
    logic [1:0]  status;
  } name_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [13:0] address;
    logic [7:0]  data;
    bit          typed;
    logic [7:0]  read_byte;
    logic [7:0]  name_length;
    logic [13:0] next_offset;
    logic [1:0]  status;
  } cmd_row_t;

  localparam int MsgBytes  = 512;
  localparam int NameBytes = 256;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam int DirRows = 19;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [13:0] in_address;
  logic [7:0]  in_data;
  logic        out_strobe;
  logic [7:0]  out_read_byte;
  logic [7:0]  out_name_length;
  logic [13:0] out_next_offset;
  logic [1:0]  out_status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  dns_name_decompressor_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_address(in_address), .in_data(in_data),
    .out_strobe(out_strobe), .out_read_byte(out_read_byte),
    .out_name_length(out_name_length), .out_next_offset(out_next_offset),
    .out_status(out_status), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Decoder model state.
  logic [7:0]  msg_image [MsgBytes];
  logic [7:0]  name_image [NameBytes];
  logic [7:0]  decoded_len;
  logic [9:0]  msg_len_reg;
  logic [6:0]  max_hops_reg;

  name_result_t pending_results [$];
  int           name_starts [$];
  logic [7:0]   staged_image [MsgBytes];
  cmd_row_t     dir_rows [DirRows];
  int           mismatches;
  int           items_sent;
  bit           quiet;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Walks one name the way the block does; returns the status.
  function automatic logic [1:0] walk_name(input int unsigned start_pos,
                                           output int unsigned len,
                                           output int unsigned next);
    int unsigned lim, pos, hops, ret, n, b, need;
    bit ret_set;
    lim = (msg_len_reg < MsgBytes) ? 32'(msg_len_reg) : MsgBytes;
    pos = start_pos;
    hops = 0;
    ret = 0;
    ret_set = 0;
    n = 0;
    len = 0;
    next = 0;
    forever begin
      if (pos >= lim) return dnd_pkg::ST_RANGE;
      b = 32'(msg_image[pos]);
      if (b == 0) begin
        len = n;
        next = (ret_set ? ret : pos + 1) & 32'h3fff;
        return dnd_pkg::ST_OK;
      end
      if ((b & 32'hc0) != 0) begin
        if (pos + 1 >= lim) return dnd_pkg::ST_RANGE;
        hops++;
        if (hops > max_hops_reg) return dnd_pkg::ST_HOPS;
        if (!ret_set) begin
          ret = pos + 2;
          ret_set = 1;
        end
        pos = ((b << 8) | msg_image[pos + 1]) & 32'h3fff;
      end else begin
        if (pos + b >= lim) return dnd_pkg::ST_RANGE;
        need = n + ((n > 0) ? 1 : 0) + b;
        if (need > NameBytes - 1) return dnd_pkg::ST_LONG;
        if (n > 0) begin
          name_image[n] = dnd_pkg::DOT_CHAR;
          n++;
        end
        for (int i = 1; i <= b; i++) begin
          name_image[n] = msg_image[pos + i];
          n++;
        end
        pos += b + 1;
      end
    end
  endfunction

  // Applies one accepted command to the model and returns its result.
  function automatic name_result_t predict_result(input logic [1:0] f,
                                                  input logic [13:0] a,
                                                  input logic [7:0] d);
    name_result_t r;
    int unsigned len, next;
    r = '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_OK};
    case (f)
      dnd_pkg::FUNC_LOAD: begin
        if (a < MsgBytes) msg_image[a] = d;
        else r.status = dnd_pkg::ST_RANGE;
      end
      dnd_pkg::FUNC_DECODE: begin
        r.status = walk_name(a, len, next);
        if (r.status == dnd_pkg::ST_OK) begin
          decoded_len = len[7:0];
          r.name_length = decoded_len;
          r.next_offset = next[13:0];
        end else begin
          decoded_len = 8'd0;
        end
      end
      dnd_pkg::FUNC_READ: begin
        if (a < decoded_len && a < NameBytes) r.read_byte = name_image[a];
        r.name_length = decoded_len;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sends one command beat, with an optional idle burst ahead of it.
  task automatic send_cmd(input logic [1:0] f, input logic [13:0] a,
                          input logic [7:0] d, input bit typed,
                          input name_result_t typed_exp);
    name_result_t p;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start      <= 1'b1;
    in_func    <= f;
    in_address <= a;
    in_data    <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = predict_result(f, a, d);
    pending_results.push_back(typed ? typed_exp : p);
    items_sent++;
  endtask

  task automatic send_checked(input logic [1:0] f, input logic [13:0] a,
                              input logic [7:0] d);
    send_cmd(f, a, d, 1'b0, '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_OK});
  endtask

  // Stops issuing and waits until every result beat has come back.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == dnd_pkg::REG_MSG_LEN) msg_len_reg = value[9:0];
    else max_hops_reg = value[6:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Builds the image used by the hand-picked commands.
  task automatic stage_directed_image();
    logic [7:0] fixed [34];
    fixed = '{8'd3, "w", "w", "w", 8'd7, "e", "x", "a", "m", "p", "l", "e",
              8'd3, "c", "o", "m", 8'd0,
              8'hc0, 8'h00,
              8'd4, "m", "a", "i", "l", 8'hc0, 8'h04,
              8'hc0, 8'h11,
              8'hc0, 8'h1c,
              8'h00,
              8'h40, 8'h00,
              8'h80};
    for (int i = 0; i < MsgBytes; i++) staged_image[i] = 8'($urandom);
    for (int i = 0; i < 34; i++) staged_image[i] = fixed[i];
    staged_image[34] = 8'h1e;
    // Four labels of 63 bytes give exactly the longest legal name.
    for (int l = 0; l < 4; l++) begin
      staged_image[64 + l * 64] = 8'd63;
      for (int i = 1; i < 64; i++) staged_image[64 + l * 64 + i] = "a";
    end
    staged_image[320] = 8'd0;
    staged_image[321] = 8'd1;
    staged_image[322] = "z";
    staged_image[323] = 8'hc0;
    staged_image[324] = 8'h40;
    staged_image[510] = 8'd5;
    staged_image[511] = 8'hc0;
    name_starts = '{0, 17, 19, 26, 28, 30, 31, 33, 64, 321};
  endtask

  // Writes one random name (labels, then end byte or pointer) at start_pos.
  task automatic load_random_name(input int start_pos);
    logic [7:0] bytes [$];
    int labels, len, tgt;
    labels = $urandom_range(0, 4);
    for (int l = 0; l < labels; l++) begin
      len = $urandom_range(1, 12);
      bytes.push_back(8'(len));
      for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: bytes.push_back(8'd0);
      5, 6, 7, 8: begin
        tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
        bytes.push_back(8'hc0 | 8'(tgt >> 8));
        bytes.push_back(8'(tgt));
      end
      default: begin
        bytes.push_back(8'($urandom_range(64, 255)));
        bytes.push_back(8'($urandom));
      end
    endcase
    foreach (bytes[i]) begin
      if (start_pos + i < MsgBytes)
        send_checked(dnd_pkg::FUNC_LOAD, 14'(start_pos + i), bytes[i]);
    end
    name_starts.push_back(start_pos);
  endtask

  // Result checker.
  always @(posedge clk) begin
    name_result_t e;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (out_read_byte !== e.read_byte || out_name_length !== e.name_length ||
            out_next_offset !== e.next_offset || out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                     $realtime, e.read_byte, e.name_length, e.next_offset, e.status,
                     out_read_byte, out_name_length, out_next_offset, out_status);
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #60000000;
    $display("Some tests failed");
    $finish;
  end

  // Main sequence.
  initial begin
    int mlen, hops, pick;
    logic [13:0] a;
    rst_n      = 1'b0;
    start      = 1'b0;
    in_func    = dnd_pkg::FUNC_LOAD;
    in_address = '0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    mismatches = 0;
    items_sent = 0;
    quiet      = 1'b0;
    decoded_len  = 8'd0;
    msg_len_reg  = dnd_pkg::MSG_LEN_RST;
    max_hops_reg = dnd_pkg::MAX_HOPS_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset the message is empty, so nothing can be decoded.
    send_cmd(dnd_pkg::FUNC_READ, 14'd0, 8'd0, 1'b1,
             '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_OK});
    send_cmd(dnd_pkg::FUNC_DECODE, 14'd0, 8'd0, 1'b1,
             '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_RANGE});
    send_cmd(dnd_pkg::FUNC_DECODE, 14'h3fff, 8'hff, 1'b1,
             '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_RANGE});
    send_cmd(dnd_pkg::FUNC_LOAD, 14'd512, 8'hff, 1'b1,
             '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_RANGE});
    send_cmd(dnd_pkg::FUNC_LOAD, 14'h3fff, 8'h00, 1'b1,
             '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_RANGE});
    send_cmd(FUNC_NOP, 14'h3fff, 8'hff, 1'b1, '{8'd0, 8'd0, 14'd0, dnd_pkg::ST_OK});

    // Fill the whole store so that every later decode reads written bytes.
    stage_directed_image();
    for (int i = 0; i < MsgBytes; i++)
      send_checked(dnd_pkg::FUNC_LOAD, 14'(i), staged_image[i]);
    drain();
    write_reg(dnd_pkg::REG_MSG_LEN, 32'd512);
    write_reg(dnd_pkg::REG_MAX_HOPS, 32'd16);

    // Hand-picked names: plain, pointers, chains, loop, root, long, bounds.
    dir_rows = '{
      '{dnd_pkg::FUNC_DECODE, 14'd0,   8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_READ,   14'd0,   8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_READ,   14'd14,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd17,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd19,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_READ,   14'd4,   8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd26,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd28,  8'd0, 1'b1, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_HOPS},
      '{dnd_pkg::FUNC_DECODE, 14'd30,  8'd0, 1'b1, 8'd0, 8'd0,   14'd31, dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd31,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd33,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd64,  8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_READ,   14'd254, 8'd0, 1'b0, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_READ,   14'd255, 8'd0, 1'b1, 8'd0, 8'd255, 14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd321, 8'd0, 1'b1, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_LONG},
      '{dnd_pkg::FUNC_READ,   14'd0,   8'd0, 1'b1, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_OK},
      '{dnd_pkg::FUNC_DECODE, 14'd510, 8'd0, 1'b1, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_RANGE},
      '{dnd_pkg::FUNC_DECODE, 14'd511, 8'd0, 1'b1, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_RANGE},
      '{dnd_pkg::FUNC_DECODE, 14'd512, 8'd0, 1'b1, 8'd0, 8'd0,   14'd0,  dnd_pkg::ST_RANGE}
    };
    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].func, dir_rows[i].address, dir_rows[i].data, dir_rows[i].typed,
               '{dir_rows[i].read_byte, dir_rows[i].name_length,
                 dir_rows[i].next_offset, dir_rows[i].status});
    end

    // Random episodes: load names, set registers, then decode and read.
    while (items_sent < 1500) begin
      if (items_sent > 1300) quiet = 1'b1;
      for (int n = $urandom_range(1, 3); n > 0; n--) load_random_name($urandom_range(0, 500));
      drain();
      case ($urandom_range(0, 5))
        0:       mlen = 0;
        1:       mlen = 512;
        2:       mlen = 1023;
        3:       mlen = $urandom_range(0, 1023);
        default: mlen = $urandom_range(256, 512);
      endcase
      case ($urandom_range(0, 6))
        0:       hops = 0;
        1:       hops = 1;
        2:       hops = 64;
        3:       hops = 127;
        default: hops = $urandom_range(1, 16);
      endcase
      write_reg(dnd_pkg::REG_MSG_LEN, {22'($urandom_range(0, 4194303)), 10'(mlen)});
      write_reg(dnd_pkg::REG_MAX_HOPS, {25'($urandom_range(0, 33554431)), 7'(hops)});
      for (int k = 0; k < 14; k++) begin
        pick = $urandom_range(0, 19);
        if (pick < 9) begin
          send_checked(dnd_pkg::FUNC_DECODE,
                       14'(name_starts[$urandom_range(0, name_starts.size() - 1)]),
                       8'($urandom));
        end else if (pick < 12) begin
          a = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(0, 600));
          send_checked(dnd_pkg::FUNC_DECODE, a, 8'($urandom));
        end else if (pick < 18) begin
          a = ($urandom_range(0, 7) == 0) ? 14'($urandom)
                                          : 14'($urandom_range(0, decoded_len + 2));
          send_checked(dnd_pkg::FUNC_READ, a, 8'($urandom));
        end else if (pick == 18) begin
          send_checked(FUNC_NOP, 14'($urandom), 8'($urandom));
        end else begin
          // Stray load, sometimes beyond the store.
          a = ($urandom_range(0, 1) == 0) ? 14'($urandom) : 14'($urandom_range(0, 511));
          send_checked(dnd_pkg::FUNC_LOAD, a, 8'($urandom));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
design/dnd_pkg.sv
design/dnd_front.sv
design/dnd_back.sv
design/dns_name_decompressor_unit.sv
sim/testbench.sv
